// ----- sv/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler-to-quaternion block
// Fixed-point constants, CORDIC angle table and the queue word type.
// ----------------------------------------------------------------------------
package e2q_pkg;
   localparam int ANGLE_W       = 16;
   localparam int QUAT_W        = 16;
   localparam int CW            = 34;   // CORDIC datapath, Q2.30 plus headroom
   localparam int ATAN_ENTRIES  = 24;
   localparam int DEF_TRIG_ITERATIONS = 16;
   localparam int DEF_QUEUE_DEPTH     = 4;

   localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] yaw;
   } angles_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] x;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] z;
      logic signed [QUAT_W-1:0] w;
   } quat_type;

   function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
      logic signed [CW-1:0] r;
      r = '0;
      case (i)
         5'd0:  r = 34'sd843314856;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

// ----- sv/e2q_queue.sv -----
// ----------------------------------------------------------------------------
// e2q_queue: small FIFO of angle words between the input ports and the back
// Register-array queue with one push and one pop port per cycle.
// ----------------------------------------------------------------------------
module e2q_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  e2q_pkg::angles_type push_word,
   output logic                full,
   input  logic                pop,
   output e2q_pkg::angles_type pop_word,
   output logic                empty
);
   import e2q_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   angles_type        mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_word;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- sv/e2q_sincos.sv -----
// ----------------------------------------------------------------------------
// e2q_sincos: pipelined CORDIC giving sine and cosine of a half angle
// Fold stage, one stage per iteration, sign-restore stage. Advances on en.
// ----------------------------------------------------------------------------
module e2q_sincos #(
   parameter int ITER = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
   output logic signed [e2q_pkg::CW-1:0]  sin_out,
   output logic signed [e2q_pkg::CW-1:0]  cos_out
);
   import e2q_pkg::*;
   localparam int N = (ITER > ATAN_ENTRIES) ? ATAN_ENTRIES : ((ITER < 1) ? 1 : ITER);

   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [CW-1:0] z_ff [N+1];
   logic                 flip_ff [N+1];
   logic signed [CW-1:0] z0, sin_ff, cos_ff;

   assign z0 = {{(CW-ANGLE_W-16){angle[ANGLE_W-1]}}, angle, 16'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         if (z0 > Q30_HALF_PI) begin
            z_ff[0] <= z0 - Q30_PI; flip_ff[0] <= 1'b1;
         end else if (z0 < -Q30_HALF_PI) begin
            z_ff[0] <= z0 + Q30_PI; flip_ff[0] <= 1'b1;
         end else begin
            z_ff[0] <= z0; flip_ff[0] <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(5'(i));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= flip_ff[N] ? -x_ff[N] : x_ff[N];
         sin_ff <= flip_ff[N] ? -y_ff[N] : y_ff[N];
      end
   end
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule

// ----- sv/e2q_back.sv -----
// ----------------------------------------------------------------------------
// e2q_back: trig and product pipeline with output skid queue
// Pulls angle words while the result queue has room for all in flight.
// ----------------------------------------------------------------------------
module e2q_back #(
   parameter int ITER = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  e2q_pkg::angles_type in_word,
   output logic                in_take,
   output e2q_pkg::quat_type   out_word,
   output logic                out_empty,
   input  logic                out_pop
);
   import e2q_pkg::*;
   localparam int N    = (ITER > ATAN_ENTRIES) ? ATAN_ENTRIES : ((ITER < 1) ? 1 : ITER);
   localparam int LAT  = N + 2 + 3;       // trig + first product + second + output
   localparam int ODEP = LAT + 2;
   localparam int OAW  = $clog2(ODEP);
   localparam int PW   = 2*CW;

   logic                 vld_ff [LAT];
   logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;
   logic [OAW:0]         ocnt_ff, infl_ff;
   logic                 en;

   // the pipeline always advances; admission is limited by free queue room
   assign en = 1'b1;

   e2q_sincos #(.ITER(N)) u_r (.clock, .en, .angle(in_word.roll),  .sin_out(sr), .cos_out(cr));
   e2q_sincos #(.ITER(N)) u_p (.clock, .en, .angle(in_word.pitch), .sin_out(sp), .cos_out(cp));
   e2q_sincos #(.ITER(N)) u_y (.clock, .en, .angle(in_word.yaw),   .sin_out(sy), .cos_out(cy));

   function automatic logic signed [CW-1:0] mq(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
      logic signed [PW-1:0] p;
      p = a * b + (PW'(1) <<< 29);
      return CW'(p >>> 30);
   endfunction

   function automatic logic signed [QUAT_W-1:0] q14(input logic signed [CW:0] v);
      logic signed [CW:0] r;
      r = (v + (CW+1)'(32768)) >>> 16;
      if (r > (CW+1)'(16384)) r = (CW+1)'(16384);
      else if (r < -(CW+1)'(16384)) r = -(CW+1)'(16384);
      return r[QUAT_W-1:0];
   endfunction

   // two-factor products
   logic signed [CW-1:0] srcp_ff, crsp_ff, crcp_ff, srsp_ff, cy_ff, sy_ff;
   // three-factor products
   logic signed [CW-1:0] a_ff [8];
   quat_type             q_ff;

   always_ff @(posedge clock) begin
      srcp_ff <= mq(sr, cp);
      crsp_ff <= mq(cr, sp);
      crcp_ff <= mq(cr, cp);
      srsp_ff <= mq(sr, sp);
      cy_ff   <= cy;
      sy_ff   <= sy;
      a_ff[0] <= mq(srcp_ff, cy_ff);
      a_ff[1] <= mq(crsp_ff, sy_ff);
      a_ff[2] <= mq(crsp_ff, cy_ff);
      a_ff[3] <= mq(srcp_ff, sy_ff);
      a_ff[4] <= mq(crcp_ff, sy_ff);
      a_ff[5] <= mq(srsp_ff, cy_ff);
      a_ff[6] <= mq(crcp_ff, cy_ff);
      a_ff[7] <= mq(srsp_ff, sy_ff);
      q_ff.x  <= q14((CW+1)'(a_ff[0]) - (CW+1)'(a_ff[1]));
      q_ff.y  <= q14((CW+1)'(a_ff[2]) + (CW+1)'(a_ff[3]));
      q_ff.z  <= q14((CW+1)'(a_ff[4]) - (CW+1)'(a_ff[5]));
      q_ff.w  <= q14((CW+1)'(a_ff[6]) + (CW+1)'(a_ff[7]));
   end

   // a word is taken only while in-flight count plus queued results is below the queue depth
   assign in_take = in_valid && ((infl_ff + ocnt_ff) < (OAW+1)'(ODEP));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_take;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // result queue
   quat_type       om_ff [ODEP];
   logic [OAW-1:0] ow_ff, or_ff;
   logic           opush, opop;
   assign opush     = vld_ff[LAT-1];
   assign out_empty = (ocnt_ff == '0);
   assign opop      = out_pop && !out_empty;
   assign out_word  = om_ff[or_ff];

   always_ff @(posedge clock) begin
      if (opush) om_ff[ow_ff] <= q_ff;
      if (reset) begin
         ow_ff <= '0; or_ff <= '0; ocnt_ff <= '0; infl_ff <= '0;
      end else begin
         if (opush) ow_ff <= (ow_ff == OAW'(ODEP-1)) ? '0 : ow_ff + 1'b1;
         if (opop)  or_ff <= (or_ff == OAW'(ODEP-1)) ? '0 : or_ff + 1'b1;
         ocnt_ff <= ocnt_ff + (OAW+1)'(opush) - (OAW+1)'(opop);
         infl_ff <= infl_ff + (OAW+1)'(in_take) - (OAW+1)'(opush);
      end
   end
endmodule

// ----- sv/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion: roll/pitch/yaw to unit quaternion (ZYX sequence)
// Front queue accepts angle words; back pipeline runs CORDIC and products.
// ----------------------------------------------------------------------------
//   channel | ports                         | handshake
//   input   | req_*_angle                   | push / full
//   result  | rsp_quat_x/y/z/w              | pop / empty
//
// One word accepted per cycle sustained while results are popped. An accepted
// word passes the front queue, the fold stage, one stage per iteration
// (iterations clamped to 1..24), sign restore, two product stages, output
// rounding and the write into the result queue.
// Reset clears queue pointers and counts, the in-flight count and pipeline valid bits only.
// A stalled result side fills the result queue, then the input queue,
// then raises full; no word is dropped.
module euler_to_quaternion #(
   parameter int TRIG_ITERATIONS = e2q_pkg::DEF_TRIG_ITERATIONS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [e2q_pkg::ANGLE_W-1:0]  req_roll_angle,
   input  logic signed [e2q_pkg::ANGLE_W-1:0]  req_pitch_angle,
   input  logic signed [e2q_pkg::ANGLE_W-1:0]  req_yaw_angle,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [e2q_pkg::QUAT_W-1:0]   rsp_quat_x,
   output logic signed [e2q_pkg::QUAT_W-1:0]   rsp_quat_y,
   output logic signed [e2q_pkg::QUAT_W-1:0]   rsp_quat_z,
   output logic signed [e2q_pkg::QUAT_W-1:0]   rsp_quat_w
);
   import e2q_pkg::*;

   angles_type in_word, q_word;
   quat_type   res;
   logic       q_empty, take;

   assign in_word = '{roll: req_roll_angle, pitch: req_pitch_angle, yaw: req_yaw_angle};

   // front: hold accepted words until the back has room
   e2q_queue #(.DEPTH(DEF_QUEUE_DEPTH)) u_front (
      .clock, .reset, .push, .push_word(in_word), .full,
      .pop(take), .pop_word(q_word), .empty(q_empty)
   );

   // back: advance the trig and product pipeline
   e2q_back #(.ITER(TRIG_ITERATIONS)) u_back (
      .clock, .reset, .in_valid(!q_empty), .in_word(q_word), .in_take(take),
      .out_word(res), .out_empty(empty), .out_pop(pop)
   );

   assign rsp_quat_x = res.x;
   assign rsp_quat_y = res.y;
   assign rsp_quat_z = res.z;
   assign rsp_quat_w = res.w;
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for euler_to_quaternion
// Drives angle words through the push/full queue and pops quaternion words
// with random stalls; a local CORDIC and product predictor checks every word.
// ----------------------------------------------------------------------------
module tb;
   import e2q_pkg::*;

   localparam int ITERS      = DEF_TRIG_ITERATIONS;
   localparam int LATENCY    = ITERS + 12;
   localparam int IDLE_LIMIT = 2000;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic signed [ANGLE_W-1:0] req_roll_angle;
   logic signed [ANGLE_W-1:0] req_pitch_angle;
   logic signed [ANGLE_W-1:0] req_yaw_angle;
   logic empty;
   logic pop;
   logic signed [QUAT_W-1:0] rsp_quat_x;
   logic signed [QUAT_W-1:0] rsp_quat_y;
   logic signed [QUAT_W-1:0] rsp_quat_z;
   logic signed [QUAT_W-1:0] rsp_quat_w;

   quat_type expected_quats[$];
   int       error_count;
   int       idle_cycles;
   int       burst_left;

   euler_to_quaternion #(.TRIG_ITERATIONS(ITERS)) u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_roll_angle(req_roll_angle), .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle(req_yaw_angle), .empty(empty), .pop(pop),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor shift; >>> on a signed longint already rounds toward minus infinity.
   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_entry(int i);
      longint tbl[24] = '{843314856, 497837829, 263043836, 133525158,
         67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
         524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047,
         1023, 511, 255, 127};
      return tbl[i];
   endfunction

   // Sine and cosine of half the angle, Q2.30, after folding into +-pi/2.
   task automatic half_sin_cos(input logic signed [ANGLE_W-1:0] ang,
                               output longint s, output longint c);
      longint z, x, y, nx;
      bit     flip;
      int     n;
      z = longint'(ang) * 65536;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      n = (ITERS > 24) ? 24 : ((ITERS < 1) ? 1 : ITERS);
      if (z > 1686629713) begin
         z -= 64'sd3373259426;
         flip = 1'b1;
      end else if (z < -1686629713) begin
         z += 64'sd3373259426;
         flip = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         if (z >= 0) begin
            nx = x - fshr(y, i);
            y  = y + fshr(x, i);
            z -= atan_entry(i);
         end else begin
            nx = x + fshr(y, i);
            y  = y - fshr(x, i);
            z += atan_entry(i);
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic longint prod3(longint a, longint b, longint c);
      longint ab;
      ab = fshr(a * b + (64'sd1 <<< 29), 30);
      return fshr(ab * c + (64'sd1 <<< 29), 30);
   endfunction

   function automatic logic signed [QUAT_W-1:0] round_q14(longint v);
      longint r;
      r = fshr(v + 32768, 16);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return QUAT_W'(r);
   endfunction

   task automatic predict_quat(input angles_type a, output quat_type q);
      longint sr, cr, sp, cp, sy, cy;
      half_sin_cos(a.roll, sr, cr);
      half_sin_cos(a.pitch, sp, cp);
      half_sin_cos(a.yaw, sy, cy);
      q.x = round_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
      q.y = round_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
      q.z = round_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
      q.w = round_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
   endtask

   // Send one angle word: honor bursts and gaps, hold push until accepted.
   task automatic send_angles(input logic signed [ANGLE_W-1:0] r,
                              input logic signed [ANGLE_W-1:0] p,
                              input logic signed [ANGLE_W-1:0] y);
      angles_type a;
      quat_type   q;
      int         gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push            <= 1'b1;
      req_roll_angle  <= r;
      req_pitch_angle <= p;
      req_yaw_angle   <= y;
      @(posedge clock);
      while (full) @(posedge clock);
      a = '{roll: r, pitch: p, yaw: y};
      predict_quat(a, q);
      expected_quats.push_back(q);
      // Leave push high; the next word or the final drop follows in this step.
   endtask

   task automatic test_extremes();
      logic signed [ANGLE_W-1:0] vals[8] = '{16'sh8000, 16'sh7FFF, 16'sh0000,
         16'shFFFF, 16'sh0001, 16'sd12868, -16'sd12868, 16'sd25736};
      for (int i = 0; i < 8; i++) send_angles(vals[i], vals[(i+3)%8], vals[(i+5)%8]);
      send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_angles(16'sh8000, 16'sh8000, 16'sh8000);
      // Angles near +-pi/2 give half angles near +-pi/4, too small to force the fold.
      send_angles(16'sd12869, -16'sd12869, 16'sd12867);
      send_angles(16'sh5555, 16'shAAAA, 16'sh0000);
   endtask

   task automatic test_single_axis();
      for (int i = 0; i < 6; i++) begin
         logic signed [ANGLE_W-1:0] v;
         v = ANGLE_W'($urandom);
         case (i % 3)
            0: send_angles(v, '0, '0);
            1: send_angles('0, v, '0);
            default: send_angles('0, '0, v);
         endcase
      end
   endtask

   task automatic test_random();
      for (int i = 0; i < 650; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_angles(ANGLE_W'($urandom_range(0, 400) - 200), ANGLE_W'($urandom),
                        ANGLE_W'($urandom_range(0, 400) - 200));
         else
            send_angles(ANGLE_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom));
      end
   endtask

   // Receiver: stall pattern from a rotating mask, with quiet stretches.
   logic [15:0] stall_mask;
   int          stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         pop         <= 1'b0;
         stall_mask  <= 16'h0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 64;
         if (stall_phase == 0) begin
            stall_mask <= ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
         end
         pop <= ~stall_mask[stall_phase % 16];
      end
   end

   // Check each popped word against the oldest expectation.
   always @(posedge clock) begin
      quat_type q;
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (pop && !empty) begin
            if (expected_quats.size() == 0) begin
               $display("%0t: unexpected word x=%0d y=%0d z=%0d w=%0d", $time,
                        rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
               error_count++;
            end else begin
               q = expected_quats.pop_front();
               if (rsp_quat_x !== q.x || rsp_quat_y !== q.y
                   || rsp_quat_z !== q.z || rsp_quat_w !== q.w) begin
                  $display("%0t: expected x=%0d y=%0d z=%0d w=%0d", $time,
                           q.x, q.y, q.z, q.w);
                  $display("%0t: actual   x=%0d y=%0d z=%0d w=%0d", $time,
                           rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      wait (!reset);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      error_count     = 0;
      idle_cycles     = 0;
      burst_left      = 0;
      reset           = 1'b1;
      push            = 1'b0;
      req_roll_angle  = '0;
      req_pitch_angle = '0;
      req_yaw_angle   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_single_axis();
      test_random();
      push <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule

// ----- euler_to_quaternion.f -----
sv/e2q_pkg.sv
sv/e2q_queue.sv
sv/e2q_sincos.sv
sv/e2q_back.sv
sv/euler_to_quaternion.sv
tb/tb.sv
